### rtl/mqrb_pkg.sv
// Shared types and constants for the multi-queue ring buffer.
package mqrb_pkg;

   // Fixed field widths of the item and result channels and of capacity_log2
   localparam int OP_W       = 2;
   localparam int QIDX_W     = 3;
   localparam int DATA_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int CAP_W      = 3;

   // Register port geometry
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address / 4)
   localparam logic [CSR_ADDR_W-3:0] REG_CAPACITY_LOG2 = 1'b0;

   // Reset value of capacity_log2
   localparam logic [CAP_W-1:0] CAP_LOG2_RESET = 3'd4;

   // Operation codes carried by an item
   typedef enum logic [OP_W-1:0] {
      OP_PUT   = 2'd0,
      OP_GET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_FULL_EMPTY = 2'd1,
      ST_BAD_INDEX  = 2'd2
   } status_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_item;      // capture the accepted item
      logic commit;         // apply counter update, store write or store read
      logic load_rsp_exec;  // load result register from the execute decision
      logic load_rsp_read;  // load result register from the store read data
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic read_needed;    // item is a get on a non-empty valid queue
      logic rsp_busy;       // result register holds an item not taken this cycle
   } dp_stat_type;

endpackage

### rtl/multi_queue_ring_buffer_top.sv
// Top level of the multi-queue ring buffer: register port and module wiring.
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    operation, queue_index, data_in
//  rsp      out        rsp_valid/rsp_ready    status, data_out
//  csr      in/out     APB psel/penable       capacity_log2 at byte address 0
//
// A put, queue reset, bad index, unused operation or get on an empty queue is
// decided in execute: rsp_valid rises and req_ready returns at the same edge, after
// which the next item can be accepted. A get on a non-empty queue also passes
// through the registered read of the single-port element store.
// On reset all queues are empty and capacity_log2 = 4; there is no store clear pass.
// A result waiting on rsp_ready does not block acceptance of the next item;
// that item then waits in execute, or a get in the read state, until the result register frees.
module multi_queue_ring_buffer_top #(
   parameter int QUEUE_COUNT   = 4,
   parameter int QUEUE_DEPTH   = 16,
   parameter int ELEMENT_BYTES = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // item channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mqrb_pkg::OP_W-1:0]           req_operation,
   input  logic [mqrb_pkg::QIDX_W-1:0]         req_queue_index,
   input  logic [mqrb_pkg::DATA_W-1:0]         req_data_in,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mqrb_pkg::STATUS_W-1:0]       rsp_status,
   output logic [mqrb_pkg::DATA_W-1:0]         rsp_data_out,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mqrb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mqrb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mqrb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [mqrb_pkg::CAP_W-1:0] capacity_log2_ff;
   logic                       csr_hit;
   mqrb_pkg::dp_cmd_type       cmd;
   mqrb_pkg::dp_stat_type      stat;

   // Register decode
   assign csr_hit    = (csr_paddr[mqrb_pkg::CSR_ADDR_W-1:2] == mqrb_pkg::REG_CAPACITY_LOG2);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_log2_ff <= mqrb_pkg::CAP_LOG2_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         capacity_log2_ff <= csr_pwdata[mqrb_pkg::CAP_W-1:0];
      end
   end

   assign csr_prdata = csr_hit ? mqrb_pkg::CSR_DATA_W'(capacity_log2_ff) : '0;

   // Sequencer
   mqrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Counters, store and result register
   mqrb_datapath #(
      .QUEUE_COUNT   (QUEUE_COUNT),
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .ELEMENT_BYTES (ELEMENT_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .capacity_log2   (capacity_log2_ff),
      .req_operation   (req_operation),
      .req_queue_index (req_queue_index),
      .req_data_in     (req_data_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

### rtl/mqrb_ctrl.sv
// Sequencing state machine for the multi-queue ring buffer.
module mqrb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mqrb_pkg::dp_stat_type stat,
   output mqrb_pkg::dp_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load_item = 1'b1;
               state_in      = S_EXEC;
               req_ready_in  = 1'b0;
            end
         end
         S_EXEC: begin
            priority if (stat.read_needed) begin
               // issue the store read; the element shows up next cycle
               cmd.commit = 1'b1;
               state_in   = S_READ;
            end else if (!stat.rsp_busy) begin
               cmd.commit        = 1'b1;
               cmd.load_rsp_exec = 1'b1;
               state_in          = S_IDLE;
               req_ready_in      = 1'b1;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_READ: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp_read = 1'b1;
               state_in          = S_IDLE;
               req_ready_in      = 1'b1;
            end
         end
         default: begin
            state_in     = S_IDLE;
            req_ready_in = 1'b1;
         end
      endcase
   end

   // State and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready = req_ready_ff;

endmodule

### rtl/mqrb_datapath.sv
// Queue counters, shared element store and result register.
module mqrb_datapath #(
   parameter int QUEUE_COUNT   = 4,
   parameter int QUEUE_DEPTH   = 16,
   parameter int ELEMENT_BYTES = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [mqrb_pkg::CAP_W-1:0]      capacity_log2,
   input  logic [mqrb_pkg::OP_W-1:0]       req_operation,
   input  logic [mqrb_pkg::QIDX_W-1:0]     req_queue_index,
   input  logic [mqrb_pkg::DATA_W-1:0]     req_data_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mqrb_pkg::STATUS_W-1:0]   rsp_status,
   output logic [mqrb_pkg::DATA_W-1:0]     rsp_data_out,
   input  mqrb_pkg::dp_cmd_type            cmd,
   output mqrb_pkg::dp_stat_type           stat
);

   // largest k with 2^k <= QUEUE_DEPTH
   localparam int DEPTH_LOG2  = ((2 ** $clog2(QUEUE_DEPTH)) == QUEUE_DEPTH) ?
                                $clog2(QUEUE_DEPTH) : $clog2(QUEUE_DEPTH) - 1;
   localparam int CNT_W       = DEPTH_LOG2 + 1;
   localparam int SLOT_W      = (DEPTH_LOG2 > 0) ? DEPTH_LOG2 : 1;
   localparam int STORE_WORDS = QUEUE_COUNT * QUEUE_DEPTH;
   localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam int QSEL_W      = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam int ELEM_W      = (ELEMENT_BYTES >= 4) ? mqrb_pkg::DATA_W : 8 * ELEMENT_BYTES;

   // Captured item
   mqrb_pkg::op_type                op_ff;
   logic [mqrb_pkg::QIDX_W-1:0]     q_ff;
   logic [ELEM_W-1:0]               data_ff;

   // Per-queue head and tail counts
   logic [CNT_W-1:0]                wr_cnt_ff [QUEUE_COUNT];
   logic [CNT_W-1:0]                rd_cnt_ff [QUEUE_COUNT];

   // Element store and its registered read data
   logic [ELEM_W-1:0]               store_mem [STORE_WORDS];
   logic [ELEM_W-1:0]               rd_data_ff;

   // Result register
   logic                            rsp_valid_ff;
   mqrb_pkg::status_type            rsp_status_ff;
   logic [mqrb_pkg::DATA_W-1:0]     rsp_data_out_ff;

   // Execute-stage decode
   logic                            q_valid;
   logic [QSEL_W-1:0]               qsel;
   logic [CNT_W-1:0]                wr_sel, rd_sel, fill, cap_full;
   logic [3:0]                      cap_log2_eff;
   logic [SLOT_W-1:0]               slot_mask, slot;
   logic [ADDR_W-1:0]               addr;
   logic                            do_write, do_read, do_clear;
   mqrb_pkg::status_type            exec_status;

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= mqrb_pkg::op_type'(req_operation);
         q_ff    <= req_queue_index;
         data_ff <= req_data_in[ELEM_W-1:0];
      end
   end

   // Fill level, capacity clamp and store address
   always_comb begin
      q_valid      = {1'b0, q_ff} < (mqrb_pkg::QIDX_W + 1)'(QUEUE_COUNT);
      qsel         = q_valid ? q_ff[QSEL_W-1:0] : '0;
      wr_sel       = wr_cnt_ff[qsel];
      rd_sel       = rd_cnt_ff[qsel];
      fill         = wr_sel - rd_sel;
      cap_log2_eff = ({1'b0, capacity_log2} > 4'(DEPTH_LOG2)) ?
                     4'(DEPTH_LOG2) : {1'b0, capacity_log2};
      cap_full     = CNT_W'(1) << cap_log2_eff;
      slot_mask    = SLOT_W'(cap_full - CNT_W'(1));
      slot         = ((op_ff == mqrb_pkg::OP_PUT) ? wr_sel[SLOT_W-1:0]
                                                  : rd_sel[SLOT_W-1:0]) & slot_mask;
      addr         = ADDR_W'(qsel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
   end

   // Operation decision
   always_comb begin
      do_write    = 1'b0;
      do_read     = 1'b0;
      do_clear    = 1'b0;
      exec_status = mqrb_pkg::ST_OK;
      if (!q_valid) begin
         exec_status = mqrb_pkg::ST_BAD_INDEX;
      end else begin
         unique case (op_ff)
            mqrb_pkg::OP_PUT: begin
               if (fill >= cap_full) exec_status = mqrb_pkg::ST_FULL_EMPTY;
               else                  do_write    = 1'b1;
            end
            mqrb_pkg::OP_GET: begin
               if (fill == '0) exec_status = mqrb_pkg::ST_FULL_EMPTY;
               else            do_read     = 1'b1;
            end
            mqrb_pkg::OP_CLEAR: begin
               do_clear = 1'b1;
            end
            mqrb_pkg::OP_NOP: begin
               exec_status = mqrb_pkg::ST_OK;
            end
            default: begin
               exec_status = mqrb_pkg::ST_OK;
            end
         endcase
      end
   end

   // Head and tail counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_COUNT; i++) begin
            wr_cnt_ff[i] <= '0;
            rd_cnt_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         if (do_write) wr_cnt_ff[qsel] <= wr_sel + CNT_W'(1);
         if (do_read)  rd_cnt_ff[qsel] <= rd_sel + CNT_W'(1);
         if (do_clear) begin
            wr_cnt_ff[qsel] <= '0;
            rd_cnt_ff[qsel] <= '0;
         end
      end
   end

   // Element store: one port, write on put, registered read on get
   always_ff @(posedge clock) begin
      if (cmd.commit && do_write) store_mem[addr] <= data_ff;
      if (cmd.commit && do_read)  rd_data_ff      <= store_mem[addr];
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp_exec || cmd.load_rsp_read) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp_exec) begin
         rsp_status_ff   <= exec_status;
         rsp_data_out_ff <= '0;
      end else if (cmd.load_rsp_read) begin
         rsp_status_ff   <= mqrb_pkg::ST_OK;
         rsp_data_out_ff <= mqrb_pkg::DATA_W'(rd_data_ff);
      end
   end

   assign stat.read_needed = do_read;
   assign stat.rsp_busy    = rsp_valid_ff && !rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_out_ff;

`ifndef SYNTH
   // a result is only loaded when the register is free
   assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp_exec || cmd.load_rsp_read) |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result register overwritten before it was taken");

   // a result appears only after a load command
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load_rsp_exec || cmd.load_rsp_read))
      else $error("result valid rose without a load");

   // a queue never holds more than 2^DEPTH_LOG2 elements
   assert property (@(posedge clock) disable iff (reset)
      q_valid |-> (fill <= CNT_W'(2 ** DEPTH_LOG2)))
      else $error("queue fill above depth");

   // only a successful get carries data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != mqrb_pkg::ST_OK)) |-> (rsp_data_out_ff == '0))
      else $error("error result with nonzero data");
`endif

endmodule
